>>> hw/rtl/polynomial_atan2_approximation_defines.svh
// Assertion macros for the atan2 block; clock i_clk, synchronous reset i_rst_n.
`ifndef POLYNOMIAL_ATAN2_APPROXIMATION_DEFINES_SVH
`define POLYNOMIAL_ATAN2_APPROXIMATION_DEFINES_SVH

// Same-cycle implication.
`define PATAN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("patan: assertion failed");

// Next-cycle implication.
`define PATAN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("patan: assertion failed");

`endif

>>> hw/rtl/patan_pkg.sv
`timescale 1ns / 1ps

package patan_pkg;

    localparam int COMPONENT_WIDTH    = 16;
    localparam int ANGLE_FRAC_BITS    = 13;
    localparam int ANGLE_W            = 16;
    localparam int RATIO_W            = 16;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = RATIO_W / DIV_BITS_PER_STAGE;
    localparam int ACC_W              = 20;
    localparam int PROD_W             = ACC_W + RATIO_W + 1;
    localparam int POLY_STEPS         = 5;
    localparam int Q30_FRAC           = 30;
    localparam int ACC_SH             = Q30_FRAC - RATIO_W;
    localparam int ROUND_SH           = Q30_FRAC - ANGLE_FRAC_BITS;
    localparam int FOLD_W             = 34;

    typedef logic [COMPONENT_WIDTH-1:0] t_mag;
    typedef logic [RATIO_W-1:0]         t_ratio;
    typedef logic signed [ACC_W-1:0]    t_acc;

    localparam t_acc COEF_A = ACC_W'(-3294);
    // b, c, d, e, then zero for the final multiply
    localparam t_acc COEF_TAIL [POLY_STEPS] = '{
        ACC_W'(17435), ACC_W'(-29659), ACC_W'(1563), ACC_W'(65429), ACC_W'(0)
    };

    localparam logic signed [FOLD_W-1:0] PI_Q30      = FOLD_W'(64'sd3373259426);
    localparam logic signed [FOLD_W-1:0] HALF_PI_Q30 = FOLD_W'(64'sd1686629713);

    typedef struct packed {
        logic big_x;
        logic x_neg;
        logic x_zero;
        logic y_neg;
        logic y_zero;
    } t_side;

endpackage

>>> hw/rtl/polynomial_atan2_approximation.sv
// Four-quadrant arctangent of a signed 16-bit vector (i_vec_x, i_vec_y), giving the angle
// in radians as signed Q3.13 (-pi..pi) on o_angle. The smaller magnitude is divided by the
// larger to form a Q0.16 ratio, a fifth-order polynomial gives the first-octant angle,
// and the signs and the larger axis fold it into place; x = 0 gives +/-pi/2, y = 0 with
// negative x gives pi, and the zero vector gives 0. One vector is taken every clock
// cycle while the skid register is empty; a result passes through the input register,
// the divider (two quotient bits per stage over eight stages), five multiply/round
// stage pairs, and the fold, rounding and output registers. A skid register behind
// the output lets a held result wait without dropping the input ready at once.
`timescale 1ns / 1ps
`include "polynomial_atan2_approximation_defines.svh"

module polynomial_atan2_approximation (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    output logic                                         o_in_ready,
    input  logic signed [patan_pkg::COMPONENT_WIDTH-1:0] i_vec_x,
    input  logic signed [patan_pkg::COMPONENT_WIDTH-1:0] i_vec_y,
    output logic                                         o_out_valid,
    input  logic                                         i_out_ready,
    output logic signed [patan_pkg::ANGLE_W-1:0]         o_angle
);
    import patan_pkg::*;

    localparam logic signed [FOLD_W-1:0] RND_Q    = FOLD_W'(1) << (ROUND_SH - 1);
    localparam logic signed [FOLD_W-1:0] ANGLE_HI = FOLD_W'(2 ** (ANGLE_W - 1) - 1);
    localparam logic signed [FOLD_W-1:0] ANGLE_LO = -ANGLE_HI - FOLD_W'(1);

    logic w_en;

    // input stage
    t_mag  n_ax;
    t_mag  n_ay;
    t_side n_side;
    logic  r_s0_v;
    t_mag  r_s0_lo;
    t_mag  r_s0_hi;
    t_side r_s0_side;

    // divider and polynomial
    logic   w_div_v;
    t_ratio w_div_ratio;
    t_side  w_div_side;
    logic   w_poly_v;
    t_acc   w_poly;
    t_side  w_poly_side;

    // fold, round, output
    logic signed [FOLD_W-1:0]  n_t;
    logic signed [FOLD_W-1:0]  n_fold;
    logic                      r_fold_v;
    logic signed [FOLD_W-1:0]  r_fold;
    logic signed [FOLD_W-1:0]  n_rw;
    logic signed [FOLD_W-1:0]  n_rs;
    logic signed [ANGLE_W-1:0] n_angle;
    logic                      r_last_v;
    logic signed [ANGLE_W-1:0] r_last_angle;
    logic                      r_ov;
    logic signed [ANGLE_W-1:0] r_o;
    logic                      r_sv;
    logic signed [ANGLE_W-1:0] r_s;

    assign w_en       = !r_sv;
    assign o_in_ready = w_en;

    assign n_ax = i_vec_x[COMPONENT_WIDTH-1] ? t_mag'(-i_vec_x) : t_mag'(i_vec_x);
    assign n_ay = i_vec_y[COMPONENT_WIDTH-1] ? t_mag'(-i_vec_y) : t_mag'(i_vec_y);

    always_comb begin
        n_side.big_x  = n_ay < n_ax;
        n_side.x_neg  = i_vec_x[COMPONENT_WIDTH-1];
        n_side.x_zero = i_vec_x == '0;
        n_side.y_neg  = i_vec_y[COMPONENT_WIDTH-1];
        n_side.y_zero = i_vec_y == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_lo   <= n_side.big_x ? n_ay : n_ax;
            r_s0_hi   <= n_side.big_x ? n_ax : n_ay;
            r_s0_side <= n_side;
        end
    end

    patan_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_v),
        .i_lo    (r_s0_lo),
        .i_hi    (r_s0_hi),
        .i_side  (r_s0_side),
        .o_valid (w_div_v),
        .o_ratio (w_div_ratio),
        .o_side  (w_div_side)
    );

    patan_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_ratio (w_div_ratio),
        .i_side  (w_div_side),
        .o_valid (w_poly_v),
        .o_poly  (w_poly),
        .o_side  (w_poly_side)
    );

    assign n_t = FOLD_W'(w_poly) <<< ACC_SH;

    always_comb begin
        n_fold = '0;
        if (w_poly_side.x_zero && w_poly_side.y_zero) begin
            n_fold = '0;
        end else if (w_poly_side.big_x) begin
            if (!w_poly_side.x_neg && !w_poly_side.x_zero) begin
                n_fold = w_poly_side.y_neg ? -n_t : n_t;
            end else if (!w_poly_side.y_neg && !w_poly_side.y_zero) begin
                n_fold = PI_Q30 - n_t;
            end else if (w_poly_side.y_neg) begin
                n_fold = n_t - PI_Q30;
            end else begin
                n_fold = PI_Q30;
            end
        end else if (!w_poly_side.x_neg) begin
            n_fold = (!w_poly_side.y_neg && !w_poly_side.y_zero) ?
                     (HALF_PI_Q30 - n_t) : (n_t - HALF_PI_Q30);
        end else begin
            n_fold = (!w_poly_side.y_neg && !w_poly_side.y_zero) ?
                     (n_t + HALF_PI_Q30) : (-n_t - HALF_PI_Q30);
        end
    end

    assign n_rw = r_fold + RND_Q;
    assign n_rs = n_rw >>> ROUND_SH;

    always_comb begin
        priority if (n_rs > ANGLE_HI) begin
            n_angle = ANGLE_HI[ANGLE_W-1:0];
        end else if (n_rs < ANGLE_LO) begin
            n_angle = ANGLE_LO[ANGLE_W-1:0];
        end else begin
            n_angle = n_rs[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_v <= 1'b0;
            r_last_v <= 1'b0;
        end else if (w_en) begin
            r_fold_v <= w_poly_v;
            r_last_v <= r_fold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fold       <= n_fold;
            r_last_angle <= n_angle;
        end
    end

    // output register with skid: last stage drains whenever the skid is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_out_ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= r_last_v;
            end
        end else if (r_last_v && !r_sv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_out_ready) begin
            r_o <= r_sv ? r_s : r_last_angle;
        end
        if (r_ov && !i_out_ready && !r_sv) begin
            r_s <= r_last_angle;
        end
    end

    assign o_out_valid = r_ov;
    assign o_angle     = r_o;

    `PATAN_ASSERT_NOW(a_skid_behind_out, r_sv, r_ov)
    `PATAN_ASSERT_NEXT(a_skid_holds, r_sv && !i_out_ready, r_sv)
    `PATAN_ASSERT_NEXT(a_stall_freezes, r_sv, $stable(r_last_v) && $stable(r_last_angle))

endmodule

>>> hw/rtl/patan_div.sv
`timescale 1ns / 1ps

module patan_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  patan_pkg::t_mag    i_lo,
    input  patan_pkg::t_mag    i_hi,
    input  patan_pkg::t_side   i_side,
    output logic               o_valid,
    output patan_pkg::t_ratio  o_ratio,
    output patan_pkg::t_side   o_side
);
    import patan_pkg::*;

    typedef struct packed {
        t_mag rem;
        logic q_bit;
    } t_step;

    // restoring step; rem <= hi holds throughout, equal inputs give all ones
    function automatic t_step div_step(input t_mag rem, input t_mag hi);
        logic [COMPONENT_WIDTH:0] rem2;
        logic [COMPONENT_WIDTH:0] diff;
        t_step res;
        rem2 = {rem, 1'b0};
        diff = rem2 - {1'b0, hi};
        if (rem2 >= {1'b0, hi}) begin
            res.rem   = diff[COMPONENT_WIDTH-1:0];
            res.q_bit = 1'b1;
        end else begin
            res.rem   = rem2[COMPONENT_WIDTH-1:0];
            res.q_bit = 1'b0;
        end
        return res;
    endfunction

    logic   s_v    [DIV_STAGES+1];
    t_ratio s_q    [DIV_STAGES+1];
    t_side  s_side [DIV_STAGES+1];
    t_mag   s_rem  [DIV_STAGES];
    t_mag   s_hi   [DIV_STAGES];

    assign s_v[0]    = i_valid;
    assign s_q[0]    = '0;
    assign s_side[0] = i_side;
    assign s_rem[0]  = i_lo;
    assign s_hi[0]   = i_hi;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic   r_v;
        t_ratio r_q;
        t_side  r_side;
        t_mag   n_rem;
        t_ratio n_q;

        always_comb begin
            t_step st;
            n_rem = s_rem[k];
            n_q   = s_q[k];
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                st    = div_step(n_rem, s_hi[k]);
                n_rem = st.rem;
                n_q   = {n_q[RATIO_W-2:0], st.q_bit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q    <= n_q;
                r_side <= s_side[k];
            end
        end

        assign s_v[k+1]    = r_v;
        assign s_q[k+1]    = r_q;
        assign s_side[k+1] = r_side;

        if (k < DIV_STAGES - 1) begin : g_carry
            t_mag r_rem;
            t_mag r_hi;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_rem;
                    r_hi  <= s_hi[k];
                end
            end

            assign s_rem[k+1] = r_rem;
            assign s_hi[k+1]  = r_hi;
        end
    end

    assign o_valid = s_v[DIV_STAGES];
    assign o_ratio = s_q[DIV_STAGES];
    assign o_side  = s_side[DIV_STAGES];

endmodule

>>> hw/rtl/patan_horner.sv
`timescale 1ns / 1ps

module patan_horner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  patan_pkg::t_ratio  i_ratio,
    input  patan_pkg::t_side   i_side,
    output logic               o_valid,
    output patan_pkg::t_acc    o_poly,
    output patan_pkg::t_side   o_side
);
    import patan_pkg::*;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RATIO_W - 1);

    logic   s_v    [POLY_STEPS+1];
    t_acc   s_acc  [POLY_STEPS+1];
    t_side  s_side [POLY_STEPS+1];
    t_ratio s_r    [POLY_STEPS];

    assign s_v[0]    = i_valid;
    assign s_acc[0]  = COEF_A;
    assign s_side[0] = i_side;
    assign s_r[0]    = i_ratio;

    for (genvar k = 0; k < POLY_STEPS; k++) begin : g_step
        // multiply stage
        logic                     r_mv;
        logic signed [PROD_W-1:0] r_prod;
        t_side                    r_mside;
        logic signed [PROD_W-1:0] n_prod;
        // round and add stage
        logic                     r_av;
        t_acc                     r_acc;
        t_side                    r_aside;
        logic signed [PROD_W-1:0] n_sum;
        logic signed [PROD_W-1:0] n_shr;
        t_acc                     n_acc;

        assign n_prod = s_acc[k] * $signed({1'b0, s_r[k]});
        assign n_sum  = r_prod + RND_HALF;
        assign n_shr  = n_sum >>> RATIO_W;
        assign n_acc  = ACC_W'(n_shr) + COEF_TAIL[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv <= 1'b0;
                r_av <= 1'b0;
            end else if (i_en) begin
                r_mv <= s_v[k];
                r_av <= r_mv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod  <= n_prod;
                r_mside <= s_side[k];
                r_acc   <= n_acc;
                r_aside <= r_mside;
            end
        end

        assign s_v[k+1]    = r_av;
        assign s_acc[k+1]  = r_acc;
        assign s_side[k+1] = r_aside;

        if (k < POLY_STEPS - 1) begin : g_carry
            t_ratio r_mr;
            t_ratio r_ar;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_mr <= s_r[k];
                    r_ar <= r_mr;
                end
            end

            assign s_r[k+1] = r_ar;
        end
    end

    assign o_valid = s_v[POLY_STEPS];
    assign o_poly  = s_acc[POLY_STEPS];
    assign o_side  = s_side[POLY_STEPS];

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import patan_pkg::COMPONENT_WIDTH;
    import patan_pkg::ANGLE_W;
    import patan_pkg::ANGLE_FRAC_BITS;

    localparam int  IDLE_LIMIT   = 2000;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  RANDOM_COUNT = 600;
    localparam int  REPORT_MAX   = 10;

    localparam longint POLY_A   = -3294;
    localparam longint POLY_B   = 17435;
    localparam longint POLY_C   = -29659;
    localparam longint POLY_D   = 1563;
    localparam longint POLY_E   = 65429;
    localparam longint PI_FIX   = 64'sd3373259426;
    localparam longint HALF_PI  = 64'sd1686629713;
    localparam longint RATIO_MAX = 65535;
    localparam longint VEC_MIN  = -(64'sd1 <<< (COMPONENT_WIDTH - 1));
    localparam longint VEC_MAX  = (64'sd1 <<< (COMPONENT_WIDTH - 1)) - 1;

    typedef logic signed [COMPONENT_WIDTH-1:0] t_comp;
    typedef logic signed [ANGLE_W-1:0]         t_angle;

    typedef struct packed {
        t_comp x;
        t_comp y;
    } t_vector;

    typedef struct packed {
        t_comp  x;
        t_comp  y;
        t_angle angle;
    } t_angle_entry;

    typedef enum int {
        RX_ALWAYS,
        RX_THREE_IN_FOUR,
        RX_COIN,
        RX_LONG_STALLS
    } t_rx_mode;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   o_in_ready;
    t_comp  i_vec_x     = '0;
    t_comp  i_vec_y     = '0;
    logic   o_out_valid;
    logic   i_out_ready = 1'b0;
    t_angle o_angle;

    t_vector      pending_vectors[$];
    t_angle_entry expected_angles[$];

    int error_count = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int rx_cycle    = 0;
    int idle_cycles = 0;
    t_rx_mode rx_mode = RX_ALWAYS;

    polynomial_atan2_approximation uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic t_angle predict_angle(input t_comp vx, input t_comp vy);
        longint x, y, ax, ay, lo, hi, r, acc, t, v;
        logic   big_x;
        x = vx;
        y = vy;
        if (x == 0 && y == 0)
            return '0;
        ax    = (x < 0) ? -x : x;
        ay    = (y < 0) ? -y : y;
        big_x = ay < ax;
        lo    = big_x ? ay : ax;
        hi    = big_x ? ax : ay;
        r     = 0;
        if (hi != 0) begin
            r = (lo <<< 16) / hi;
            if (r > RATIO_MAX)
                r = RATIO_MAX;
        end
        acc = POLY_A;
        acc = round_shift(acc * r, 16) + POLY_B;
        acc = round_shift(acc * r, 16) + POLY_C;
        acc = round_shift(acc * r, 16) + POLY_D;
        acc = round_shift(acc * r, 16) + POLY_E;
        acc = round_shift(acc * r, 16);
        t   = acc * 16384;
        if (big_x) begin
            if (x > 0)
                v = (y < 0) ? -t : t;
            else if (y > 0)
                v = PI_FIX - t;
            else if (y < 0)
                v = t - PI_FIX;
            else
                v = PI_FIX;
        end else begin
            if (x >= 0)
                v = (y > 0) ? (HALF_PI - t) : (t - HALF_PI);
            else
                v = (y > 0) ? (t + HALF_PI) : (-t - HALF_PI);
        end
        v = round_shift(v, 30 - ANGLE_FRAC_BITS);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return t_angle'(v);
    endfunction

    function automatic longint clamp_component(input longint v);
        if (v > VEC_MAX)
            return VEC_MAX;
        if (v < VEC_MIN)
            return VEC_MIN;
        return v;
    endfunction

    task automatic add_vector(input longint x, input longint y);
        t_vector item;
        item.x = t_comp'(x);
        item.y = t_comp'(y);
        pending_vectors = {pending_vectors, item};
    endtask

    // Sender: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin
        t_vector      item;
        t_angle_entry entry;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = $urandom_range(1, 20);
            gap_left   = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                entry.x     = i_vec_x;
                entry.y     = i_vec_y;
                entry.angle = predict_angle(i_vec_x, i_vec_y);
                expected_angles = {expected_angles, entry};
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 || pending_vectors.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    i_in_valid <= 1'b0;
                end else begin
                    item = pending_vectors.pop_front();
                    i_vec_x    <= item.x;
                    i_vec_y    <= item.y;
                    i_in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: stall pattern is redrawn at random as rx_cycle advances, checks each transaction
    always @(posedge i_clk) begin
        t_angle_entry entry;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_angles.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("unexpected angle transaction: got %0d", o_angle);
                end else begin
                    entry = expected_angles.pop_front();
                    if (o_angle !== entry.angle) begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("angle mismatch x=%0d y=%0d: expected %0d, got %0d",
                                     entry.x, entry.y, entry.angle, o_angle);
                    end
                end
            end
            rx_cycle++;
            if (rx_cycle % 128 == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_ALWAYS:        i_out_ready <= 1'b1;
                RX_THREE_IN_FOUR: i_out_ready <= (rx_cycle % 4) != 0;
                RX_COIN:          i_out_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                        if ($urandom_range(0, 9) == 0)
                            stall_left = $urandom_range(1, 25);
                    end
                end
            endcase
        end
    end

    // Watchdog on cycles without any transaction while work is outstanding
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (pending_vectors.size() == 0 && !i_in_valid && expected_angles.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("polynomial_atan2_approximation verification failed");
                $finish;
            end
        end
    end

    initial begin
        int     kind;
        longint base, x, y;
        // zero vector, axes and extremes
        add_vector(0, 0);
        add_vector(0, 1);
        add_vector(0, -1);
        add_vector(0, VEC_MAX);
        add_vector(0, VEC_MIN);
        add_vector(1, 0);
        add_vector(-1, 0);
        add_vector(VEC_MAX, 0);
        add_vector(VEC_MIN, 0);
        // equal magnitudes saturate the ratio; near-equal and lopsided vectors follow
        add_vector(5, 5);
        add_vector(-5, 5);
        add_vector(5, -5);
        add_vector(-5, -5);
        add_vector(VEC_MAX, VEC_MAX);
        add_vector(VEC_MIN, VEC_MIN);
        add_vector(VEC_MIN, VEC_MAX);
        add_vector(VEC_MAX, VEC_MIN);
        add_vector(1, VEC_MAX);
        add_vector(VEC_MAX, 1);
        add_vector(VEC_MIN, 1);
        add_vector(1, VEC_MIN);
        add_vector(-32767, -1);
        add_vector(100, -3);
        add_vector(-3, -100);
        add_vector(VEC_MIN, -1);

        repeat (RANDOM_COUNT) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    x = $signed(16'($urandom));
                    y = $signed(16'($urandom));
                end
                4: begin
                    x = $urandom_range(0, 30) - 15;
                    y = $urandom_range(0, 30) - 15;
                end
                5, 6: begin
                    base = $urandom_range(0, 32768);
                    x = $urandom_range(0, 1) ? base : -base;
                    y = base + $urandom_range(0, 2) - 1;
                    y = $urandom_range(0, 1) ? y : -y;
                end
                7: begin
                    x = $signed(16'($urandom));
                    y = 0;
                    if ($urandom_range(0, 1)) begin
                        y = x;
                        x = 0;
                    end
                end
                default: begin
                    x = $urandom_range(0, 1) ? VEC_MIN : VEC_MAX;
                    y = $signed(16'($urandom));
                    if ($urandom_range(0, 1)) begin
                        base = x;
                        x = y;
                        y = base;
                    end
                end
            endcase
            add_vector(clamp_component(x), clamp_component(y));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_vectors.size() != 0 || i_in_valid || expected_angles.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("polynomial_atan2_approximation verification clean");
        else
            $display("polynomial_atan2_approximation verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/patan_pkg.sv
hw/rtl/patan_div.sv
hw/rtl/patan_horner.sv
hw/rtl/polynomial_atan2_approximation.sv
tb/testbench.sv
